// ===== rtl/core/pulse_channel_with_frequency_sweep_core_assert.svh =====
// Assertion macros for the pulse channel core.
`ifndef PULSE_CHANNEL_WITH_FREQUENCY_SWEEP_CORE_ASSERT_SVH
`define PULSE_CHANNEL_WITH_FREQUENCY_SWEEP_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PCFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulse channel check failed");
`define PCFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulse channel check failed");
`else
`define PCFS_ASSERT_NOW(lbl, ante, cons)
`define PCFS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/pcfs_pkg.sv =====
// Types, codes and duty table shared by the pulse channel core.
package pcfs_pkg;

    localparam logic [2:0] OP_LAPSE    = 3'd0;
    localparam logic [2:0] OP_WRITE    = 3'd1;
    localparam logic [2:0] OP_LENGTH   = 3'd2;
    localparam logic [2:0] OP_ENVELOPE = 3'd3;
    localparam logic [2:0] OP_SWEEP    = 3'd4;
    localparam logic [2:0] OP_PHASE    = 3'd5;

    localparam logic [2:0] REG_SWEEP    = 3'd0;
    localparam logic [2:0] REG_LENGTH   = 3'd1;
    localparam logic [2:0] REG_ENVELOPE = 3'd2;
    localparam logic [2:0] REG_FREQ_LO  = 3'd3;
    localparam logic [2:0] REG_FREQ_HI  = 3'd4;

    localparam logic [2:0] MAX_CYCLES = 3'd4;
    localparam logic [6:0] LENGTH_FULL = 7'd64;
    localparam logic [11:0] FREQ_LIMIT = 12'd2047;

    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic [2:0] cycle_count;
    } item_t;

    typedef struct packed {
        logic        channel_enabled;
        logic [2:0]  duty_position;
        logic [1:0]  duty_select;
        logic [6:0]  length_count;
        logic        length_enable;
        logic [2:0]  envelope_period;
        logic [2:0]  envelope_countdown;
        logic        envelope_rising;
        logic [3:0]  envelope_start_volume;
        logic [3:0]  volume;
        logic        envelope_running;
        logic [10:0] tone_frequency;
        logic [12:0] divider_count;
        logic [2:0]  sweep_shift;
        logic        sweep_down;
        logic [2:0]  sweep_period;
        logic [2:0]  sweep_countdown;
        logic        sweep_running;
        logic [10:0] shadow_frequency;
    } chan_state_t;

    typedef struct packed {
        logic [3:0] sample;
        logic       channel_on;
    } result_t;

    function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] pattern;
        unique case (sel)
            2'd0: pattern = 8'h01;
            2'd1: pattern = 8'h81;
            2'd2: pattern = 8'h87;
            default: pattern = 8'h7E;
        endcase
        return pattern[pos];
    endfunction

endpackage

// ===== rtl/core/pcfs_step.sv =====
// Next-state and sample logic for one channel event.
module pcfs_step
(
    input  pcfs_pkg::chan_state_t st,
    input  pcfs_pkg::item_t       item,
    output pcfs_pkg::chan_state_t nx,
    output pcfs_pkg::result_t     res
);
    import pcfs_pkg::*;

    logic [13:0] period;
    logic [13:0] count_sum;
    logic [13:0] count_wrap;
    logic [2:0]  cycles;
    logic [10:0] delta;
    logic [11:0] target;
    logic [10:0] delta2;
    logic [11:0] target2;
    logic        dac_on;
    logic        trig;

    always_comb
    begin
        cycles     = (item.cycle_count > MAX_CYCLES) ? MAX_CYCLES : item.cycle_count;
        period     = {(12'd2048 - {1'b0, st.tone_frequency}), 2'b00};
        count_sum  = {1'b0, st.divider_count} + {11'd0, cycles};
        count_wrap = count_sum - period;
        delta      = st.shadow_frequency >> st.sweep_shift;
        target     = st.sweep_down ? ({1'b0, st.shadow_frequency} - {1'b0, delta})
                                   : ({1'b0, st.shadow_frequency} + {1'b0, delta});
        // second check runs on the freshly stored shadow value
        delta2     = target[10:0] >> st.sweep_shift;
        target2    = st.sweep_down ? ({1'b0, target[10:0]} - {1'b0, delta2})
                                   : ({1'b0, target[10:0]} + {1'b0, delta2});
        dac_on     = (st.envelope_start_volume != 4'd0) || st.envelope_rising;
        trig       = item.write_data[7];

        nx = st;
        unique case (item.operation)
            OP_LAPSE:
            begin
                if (st.channel_enabled)
                begin
                    if (count_sum >= period)
                    begin
                        nx.duty_position = st.duty_position + 3'd1;
                        nx.divider_count = (count_wrap >= period) ? 13'd0 : count_wrap[12:0];
                    end
                    else
                    begin
                        nx.divider_count = count_sum[12:0];
                    end
                end
            end
            OP_WRITE:
            begin
                unique case (item.reg_select)
                    REG_SWEEP:
                    begin
                        nx.sweep_shift  = item.write_data[2:0];
                        nx.sweep_down   = item.write_data[3];
                        nx.sweep_period = item.write_data[6:4];
                    end
                    REG_LENGTH:
                    begin
                        nx.length_count = LENGTH_FULL - {1'b0, item.write_data[5:0]};
                        nx.duty_select  = item.write_data[7:6];
                    end
                    REG_ENVELOPE:
                    begin
                        nx.envelope_period       = item.write_data[2:0];
                        nx.envelope_countdown    = item.write_data[2:0];
                        nx.envelope_rising       = item.write_data[3];
                        nx.envelope_start_volume = item.write_data[7:4];
                        nx.channel_enabled       = (item.write_data[7:3] != 5'd0);
                    end
                    REG_FREQ_LO:
                    begin
                        nx.tone_frequency = {st.tone_frequency[10:8], item.write_data};
                    end
                    REG_FREQ_HI:
                    begin
                        nx.tone_frequency = {item.write_data[2:0], st.tone_frequency[7:0]};
                        nx.length_enable  = item.write_data[6];
                        if (trig)
                        begin
                            nx.divider_count = 13'd0;
                            if (st.length_count == 7'd0)
                                nx.length_count = LENGTH_FULL;
                            nx.envelope_countdown = st.envelope_period;
                            nx.volume             = st.envelope_start_volume;
                            nx.envelope_running   = 1'b1;
                            if (dac_on)
                                nx.channel_enabled = 1'b1;
                            nx.shadow_frequency = {item.write_data[2:0], st.tone_frequency[7:0]};
                            nx.sweep_countdown  = 3'd0;
                            nx.sweep_running    = (st.sweep_period != 3'd0)
                                               || (st.sweep_shift != 3'd0);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_LENGTH:
            begin
                if (st.length_enable && st.length_count != 7'd0)
                begin
                    nx.length_count = st.length_count - 7'd1;
                    if (st.length_count == 7'd1)
                        nx.channel_enabled = 1'b0;
                end
            end
            OP_ENVELOPE:
            begin
                if (st.channel_enabled && st.envelope_running && st.envelope_period != 3'd0)
                begin
                    if (st.envelope_countdown > 3'd1)
                    begin
                        nx.envelope_countdown = st.envelope_countdown - 3'd1;
                    end
                    else
                    begin
                        nx.envelope_countdown = st.envelope_period;
                        if (st.envelope_rising)
                        begin
                            if (st.volume != 4'hF)
                            begin
                                nx.volume = st.volume + 4'd1;
                                if (st.volume == 4'hE)
                                    nx.envelope_running = 1'b0;
                            end
                        end
                        else if (st.volume != 4'h0)
                        begin
                            nx.volume = st.volume - 4'd1;
                            if (st.volume == 4'h1)
                                nx.envelope_running = 1'b0;
                        end
                    end
                end
            end
            OP_SWEEP:
            begin
                if (st.channel_enabled && st.sweep_running && st.sweep_period != 3'd0)
                begin
                    if (st.sweep_countdown > 3'd1)
                    begin
                        nx.sweep_countdown = st.sweep_countdown - 3'd1;
                    end
                    else
                    begin
                        nx.sweep_countdown = st.sweep_period;
                        if (target > FREQ_LIMIT)
                        begin
                            nx.channel_enabled = 1'b0;
                        end
                        else
                        begin
                            nx.shadow_frequency = target[10:0];
                            nx.tone_frequency   = target[10:0];
                            if (target2 > FREQ_LIMIT)
                                nx.channel_enabled = 1'b0;
                        end
                    end
                end
            end
            OP_PHASE:
            begin
                nx.divider_count = 13'd0;
                nx.duty_position = 3'd0;
            end
            default:
            begin
            end
        endcase

        res.channel_on = nx.channel_enabled;
        res.sample     = (nx.channel_enabled && duty_bit(nx.duty_select, nx.duty_position))
                       ? nx.volume : 4'd0;
    end

endmodule

// ===== rtl/core/pulse_channel_with_frequency_sweep_core.sv =====
// Top level of the pulse channel with duty, length, envelope and sweep.
// Throughput: one event per cycle unless the output stalls; the update path is a single
// registered pass from the input register through the step logic into the result register.
// Reset: rst_n clears both stages and loads the channel's power-on state.
`include "pulse_channel_with_frequency_sweep_core_assert.svh"
module pulse_channel_with_frequency_sweep_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] write_data, [10:8] cycle_count, rest zero
    input  logic [5:0]  s_axis_tuser,  // [2:0] operation, [5:3] reg_select
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // [3:0] sample, [4] channel_on, rest zero
);
    import pcfs_pkg::*;

    // Power-on state of the channel
    localparam chan_state_t STATE_RESET = '{
        channel_enabled:       1'b1,
        duty_position:         3'd0,
        duty_select:           2'd2,
        length_count:          7'd1,
        length_enable:         1'b0,
        envelope_period:       3'd3,
        envelope_countdown:    3'd3,
        envelope_rising:       1'b0,
        envelope_start_volume: 4'd15,
        volume:                4'd15,
        envelope_running:      1'b1,
        tone_frequency:        11'h700,
        divider_count:         13'd0,
        sweep_shift:           3'd0,
        sweep_down:            1'b0,
        sweep_period:          3'd0,
        sweep_countdown:       3'd0,
        sweep_running:         1'b0,
        shadow_frequency:      11'h700
    };

    // Input stage: holds one accepted event until the result register frees up
    logic        in_valid_reg;
    logic        in_valid_next;
    item_t       in_item_reg;

    // Result stage: parts the step logic from the downstream consumer
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_res_reg;

    chan_state_t state_reg;
    chan_state_t state_next;
    result_t     step_res;

    logic        in_xfer;
    logic        advance;

    // Advance the input stage whenever the result register is empty or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (in_xfer)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    pcfs_step u_step
    (
        .st   (state_reg),
        .item (in_item_reg),
        .nx   (state_next),
        .res  (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // Commit the channel state only when the event advances into the result register
            if (advance)
                state_reg <= state_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg.operation   <= s_axis_tuser[2:0];
            in_item_reg.reg_select  <= s_axis_tuser[5:3];
            in_item_reg.write_data  <= s_axis_tdata[7:0];
            in_item_reg.cycle_count <= s_axis_tdata[10:8];
        end
        if (advance)
            out_res_reg <= step_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_res_reg.channel_on, out_res_reg.sample};

    // A nonzero sample only comes from an enabled channel
    `PCFS_ASSERT_NOW(a_sample_needs_on, m_axis_tvalid && (m_axis_tdata[3:0] != 4'd0), m_axis_tdata[4])
    // A held event is not dropped while the result register is stalled
    `PCFS_ASSERT_NEXT(a_hold_input, in_valid_reg && out_valid_reg && !m_axis_tready, in_valid_reg)
    // The length counter never exceeds a full load
    `PCFS_ASSERT_NOW(a_length_range, 1'b1, state_reg.length_count <= LENGTH_FULL)
    // Every advance of the input stage yields a result
    `PCFS_ASSERT_NEXT(a_advance_result, advance, out_valid_reg)

endmodule
